// File: hw/rtl/mgas_pkg.sv
package mgas_pkg;

  // Fixed-point formats of the ports.
  localparam int SAMPLE_W         = 16;
  localparam int DELTA_W          = 15;
  localparam int DRAW_W           = 16;
  localparam int RATIO_W          = 17;
  localparam int SAMPLE_FRAC_BITS = 12;

  // Power-of-two exponent table.
  localparam int EXP_TABLE_DEPTH = 64;
  localparam int IDX_W           = $clog2(EXP_TABLE_DEPTH);
  localparam int SERIES_TERMS    = 24;

  localparam longint unsigned LOG2E_Q30 = 64'd1549082005;
  localparam longint unsigned LN2_Q30   = 64'd744261118;
  localparam longint unsigned ONE_Q30   = 64'd1 << 30;
  localparam int              LOG2E_W   = 31;

  // Datapath widths. The action term d*(2x+d) needs 33 bits signed; its
  // positive magnitude fits in 32 bits.
  localparam int SUM_W   = SAMPLE_W + 2;
  localparam int TERM_W  = 33;
  localparam int MAG_W   = 32;
  localparam int PROD_W  = MAG_W + LOG2E_W;
  // Q2.30 exponent after scaling by 2^-(2F+1): integer part starts here.
  localparam int EXP_LSB = 2 * SAMPLE_FRAC_BITS + 1 + 30;
  localparam int K_W     = PROD_W - EXP_LSB;
  localparam int SHIFT_W = $clog2(RATIO_W);

  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(65536);

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic square;
    logic scale;
    logic commit;
  } mgas_cmd_t;

  // Entry i is 2^(-i/EXP_TABLE_DEPTH) in Q0.16, from a truncated Taylor
  // series of exp(-u) in Q2.30. Evaluated at elaboration only.
  function automatic logic [RATIO_W-1:0] exp2_entry(int unsigned i);
    longint unsigned u;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned rounded;
    int unsigned     n;
    u    = (64'(i) * LN2_Q30) / EXP_TABLE_DEPTH;
    term = ONE_Q30;
    sum  = ONE_Q30;
    for (n = 1; n <= SERIES_TERMS; n++) begin
      term = ((term * u) >> 30) / 64'(n);
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    rounded = (sum + (64'd1 << 13)) >> 14;
    return rounded[RATIO_W-1:0];
  endfunction

endpackage

// File: hw/rtl/mgas_ctrl.sv
module mgas_ctrl
  import mgas_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output mgas_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SCALE,
    ST_RESOLVE
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  assign cmd.capture = in_valid && in_ready;
  assign cmd.square  = (state == ST_SQUARE);
  assign cmd.scale   = (state == ST_SCALE);
  assign cmd.commit  = (state == ST_RESOLVE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A finishing step reloads the result register even when the old beat
      // leaves on the same edge.
      priority if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end else begin
        out_valid <= out_valid;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          state <= ST_RESOLVE;
        end
        ST_RESOLVE: begin
          // Hold the finished step until the result register is free.
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/mgas_datapath.sv
module mgas_datapath
  import mgas_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  mgas_cmd_t                  cmd,
  input  logic signed [DELTA_W-1:0]  delta,
  input  logic        [DRAW_W-1:0]   uniform_draw,
  output logic signed [SAMPLE_W-1:0] new_sample,
  output logic                       accepted,
  output logic        [RATIO_W-1:0]  step_ratio
);

  logic signed [SAMPLE_W-1:0] current_sample;
  logic signed [DELTA_W-1:0]  delta_q;
  logic        [DRAW_W-1:0]   draw_q;
  logic signed [TERM_W-1:0]   neg_t;
  logic        [PROD_W-1:0]   scaled;

  logic signed [SUM_W-1:0]    s_sum;
  logic signed [TERM_W-1:0]   term_next;
  logic        [MAG_W-1:0]    mag;
  logic        [PROD_W-1:0]   scaled_next;
  logic        [K_W-1:0]      k;
  logic        [IDX_W-1:0]    idx;
  logic        [RATIO_W-1:0]  ratio;
  logic                       acc;
  logic signed [SAMPLE_W:0]   prop;
  logic signed [SAMPLE_W-1:0] prop_sat;
  logic signed [SAMPLE_W-1:0] sample_next;
  logic        [RATIO_W-1:0]  exp_rom [EXP_TABLE_DEPTH];

  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
    assign exp_rom[g] = exp2_entry(g);
  end

  // x*x - p*p = -d*(2x + d); the register holds d*(2x + d), the negated action.
  assign s_sum     = (SUM_W'(current_sample) <<< 1) + SUM_W'(delta_q);
  assign term_next = TERM_W'(delta_q) * TERM_W'(s_sum);

  assign mag         = neg_t[MAG_W-1:0];
  assign scaled_next = PROD_W'(mag) * PROD_W'(LOG2E_Q30);

  assign k   = scaled[PROD_W-1 -: K_W];
  assign idx = scaled[EXP_LSB-1 -: IDX_W];

  always_comb begin
    if (neg_t <= 0) begin
      ratio = RATIO_ONE;
    end else if (k >= K_W'(RATIO_W)) begin
      ratio = '0;
    end else begin
      ratio = exp_rom[idx] >> k[SHIFT_W-1:0];
    end
  end

  assign acc  = RATIO_W'(draw_q) < ratio;
  assign prop = (SAMPLE_W+1)'(current_sample) + (SAMPLE_W+1)'(delta_q);

  always_comb begin
    if (prop > (SAMPLE_W+1)'(signed'(SAMPLE_W'({1'b0, {(SAMPLE_W-1){1'b1}}})))) begin
      prop_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (prop < -(SAMPLE_W+1)'(signed'({2'b01, {(SAMPLE_W-1){1'b0}}}))) begin
      prop_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      prop_sat = prop[SAMPLE_W-1:0];
    end
  end

  assign sample_next = acc ? prop_sat : current_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_sample <= '0;
    end else if (cmd.commit) begin
      current_sample <= sample_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      delta_q <= delta;
      draw_q  <= uniform_draw;
    end
    if (cmd.square) begin
      neg_t <= term_next;
    end
    if (cmd.scale) begin
      scaled <= scaled_next;
    end
    if (cmd.commit) begin
      new_sample <= sample_next;
      accepted   <= acc;
      step_ratio <= ratio;
    end
  end

endmodule

// File: hw/rtl/metropolis_gaussian_accept_step.sv
// One Metropolis random-walk step for a standard Gaussian target. The block
// keeps the current sample x (signed Q4.12, cleared by reset). Each input beat
// carries a proposal step delta (signed Q3.12) and a uniform draw (Q0.16); the
// block forms p = x + delta, the ratio min(1, exp(0.5*(x*x - p*p))) in Q0.16
// (65536 meaning one), and accepts p when the draw is below the ratio. An
// accepted proposal beyond the Q4.12 range saturates, while the ratio always
// uses the full proposal. Exactly one output beat follows each input beat,
// giving the new sample, the accept flag and the ratio. The beat is captured
// in the cycle it is taken; the square state then does the delta*(2x + delta)
// multiply, the scale state the scaling multiply by log2(e), and the resolve
// state the 64-entry power-of-two table lookup, the shift and the accept
// decision, and loads the result. The next beat is taken only after the
// previous step has updated the sample, which happens as its result is loaded,
// so items are processed one at a time; a finished result waits in the output
// register without blocking the next input beat, and the step stalls only if
// that register is still occupied.
module metropolis_gaussian_accept_step
  import mgas_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [DELTA_W-1:0]  delta,
  input  logic        [DRAW_W-1:0]   uniform_draw,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] new_sample,
  output logic                       accepted,
  output logic        [RATIO_W-1:0]  step_ratio
);

  // Commands from the sequencer to the arithmetic.
  mgas_cmd_t cmd;

  // The controller owns the handshakes and the step sequence.
  mgas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // The datapath holds the sample, the multipliers, the table and the results.
  mgas_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .delta        (delta),
    .uniform_draw (uniform_draw),
    .new_sample   (new_sample),
    .accepted     (accepted),
    .step_ratio   (step_ratio)
  );

endmodule

// File: hw/rtl/mgas_checker.sv
module mgas_checker
  import mgas_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] new_sample,
  input logic                       accepted,
  input logic        [RATIO_W-1:0]  step_ratio
);

  // A stalled result beat holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_sample) && $stable(accepted)
      && $stable(step_ratio))
    else $error("stalled result beat changed");

  // One step at a time: no beat is taken right after a taken beat.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a step is in progress");

  // The ratio never exceeds one.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> step_ratio <= RATIO_ONE)
    else $error("ratio above one");

  // A ratio of one always accepts.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && step_ratio == RATIO_ONE |-> accepted)
    else $error("proposal rejected at ratio one");

  // A ratio of zero never accepts.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && step_ratio == '0 |-> !accepted)
    else $error("proposal accepted at ratio zero");

endmodule

bind metropolis_gaussian_accept_step mgas_checker u_mgas_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .new_sample (new_sample),
  .accepted   (accepted),
  .step_ratio (step_ratio)
);
